// ===== rtl/core/abm4_pkg.sv =====
// Shared types, codes and constants for the ABM4 predictor-corrector step engine.
package abm4_pkg;

  // Field widths
  localparam int IDX_W  = 10;
  localparam int KIND_W = 3;
  localparam int VAL_W  = 32;
  // Weighted derivative sum: |S| <= 160 * 2^31 < 2^39, plus sign
  localparam int SUM_W  = 40;

  // Default element count
  localparam int ELEMENTS_DEF = 1024;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_SEED_B1 = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SEED_B2 = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SEED_B3 = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PREDICT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CORRECT = 3'd4;

  // Register file: one register, index taken from paddr[2]
  localparam int          ADDR_W        = 3;
  localparam logic        REG_STEP_SIZE = 1'b0;
  localparam logic [VAL_W-1:0] STEP_RESET = 32'h0001_0000;

  // Predictor coefficients (Adams-Bashforth)
  localparam logic signed [7:0] PC_F0 = 8'sd55;
  localparam logic signed [7:0] PC_F1 = 8'sd59;
  localparam logic signed [7:0] PC_F2 = 8'sd37;
  localparam logic signed [7:0] PC_F3 = 8'sd9;
  // Corrector coefficients (Adams-Moulton); f2 weight is one
  localparam logic signed [7:0] CC_FP = 8'sd9;
  localparam logic signed [7:0] CC_F0 = 8'sd19;
  localparam logic signed [7:0] CC_F1 = 8'sd5;

  // Scaling h*S / (24 * 2^16): split |S| at bit 19, round, then divide by 3
  // Rounding bias is half of 3 * 2^19, i.e. 3 * 2^18
  localparam int               SPLIT      = 19;
  localparam int               MS_W       = SUM_W - 1;
  localparam int               PH_W       = VAL_W + MS_W - SPLIT;
  localparam int               PL_W       = VAL_W + SPLIT;
  localparam logic [SPLIT:0]   ROUND_BIAS = 20'hC_0000;
  localparam int               Q_W        = 52;
  localparam int               Q_LO_W     = 26;
  localparam int               Q_HI_W     = Q_W - Q_LO_W;
  localparam int               A_W        = Q_HI_W - 1;
  localparam int               B_W        = Q_LO_W;
  localparam int               T_W        = Q_LO_W + 2;
  localparam int               MAG_W      = A_W + B_W;
  localparam int               RES_W      = MAG_W + 2;

  // floor(x/3) == (x * RECIP3) >> RECIP3_SHIFT for every 32-bit x
  localparam logic [31:0]      RECIP3       = 32'hAAAA_AAAB;
  localparam int               RECIP3_SHIFT = 33;
  localparam int               PROD3_W      = 64;

  // Saturation limits
  localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

  // Per-item tag carried down the arithmetic pipe
  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic                    corr;
    logic signed [VAL_W-1:0] y;
  } side_t;

  // Weighted sum handed from the history stage to the arithmetic pipe
  typedef struct packed {
    logic                    valid;
    side_t                   side;
    logic signed [SUM_W-1:0] s;
  } sum_t;

endpackage

// ===== rtl/core/abm4_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module abm4_ram #(
  parameter int WIDTH = abm4_pkg::VAL_W,
  parameter int DEPTH = abm4_pkg::ELEMENTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/abm4_hist.sv =====
// Input stage: derivative history memories, forwarding and weighted-sum formation.
module abm4_hist #(
  parameter int ELEMENTS = abm4_pkg::ELEMENTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [abm4_pkg::KIND_W-1:0]          kind,
  input  logic [abm4_pkg::IDX_W-1:0]           element_index,
  input  logic signed [abm4_pkg::VAL_W-1:0]    current_value,
  input  logic signed [abm4_pkg::VAL_W-1:0]    derivative,
  input  logic                                 adv,
  output abm4_pkg::sum_t                       sum
);

  localparam int AW     = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int WIDE_W = AW + abm4_pkg::IDX_W;
  localparam int SW     = abm4_pkg::SUM_W;

  logic                              in_fire;
  logic                              st1_valid;
  logic [abm4_pkg::KIND_W-1:0]       st1_kind;
  logic [abm4_pkg::IDX_W-1:0]        st1_idx;
  logic signed [abm4_pkg::VAL_W-1:0] st1_y;
  logic signed [abm4_pkg::VAL_W-1:0] st1_d;
  logic                              st1_in_range;
  logic                              st1_result;
  logic                              st1_go;
  logic [WIDE_W-1:0]                 rd_wide;
  logic [WIDE_W-1:0]                 wr_wide;
  logic [AW-1:0]                     rd_addr;
  logic [AW-1:0]                     wr_addr;
  logic [abm4_pkg::VAL_W-1:0]        rd_now, rd_b1, rd_b2, rd_b3;
  logic                              fwd_valid;
  logic [abm4_pkg::IDX_W-1:0]        fwd_idx;
  logic signed [abm4_pkg::VAL_W-1:0] fwd_now, fwd_b1, fwd_b2, fwd_b3;
  logic                              use_fwd;
  logic signed [abm4_pkg::VAL_W-1:0] cur_now, cur_b1, cur_b2, cur_b3;
  logic signed [abm4_pkg::VAL_W-1:0] new_now, new_b1, new_b2, new_b3;
  logic                              we_now, we_b1, we_b2, we_b3;
  logic                              wr_en;
  logic                              wr_any;
  logic signed [SW-1:0]              dx, x_now, x_b1, x_b2, x_b3;
  logic signed [SW-1:0]              sum_pred, sum_corr;

  // Handshake: the stage empties when its item needs no result slot or the pipe moves
  assign st1_in_range = 32'(st1_idx) < 32'(ELEMENTS);
  assign st1_result   = st1_in_range &&
                        ((st1_kind == abm4_pkg::KIND_PREDICT) ||
                         (st1_kind == abm4_pkg::KIND_CORRECT));
  assign st1_go       = st1_valid && (!st1_result || adv);
  assign in_ready     = !st1_valid || st1_go;
  assign in_fire      = in_valid && in_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
    end else if (in_ready) begin
      st1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      st1_kind <= kind;
      st1_idx  <= element_index;
      st1_y    <= current_value;
      st1_d    <= derivative;
    end
  end

  // Memory addressing: read on acceptance, write as the item leaves
  assign rd_wide = WIDE_W'(element_index);
  assign wr_wide = WIDE_W'(st1_idx);
  assign rd_addr = rd_wide[AW-1:0];
  assign wr_addr = wr_wide[AW-1:0];
  assign wr_en   = st1_go && st1_in_range;

  abm4_ram #(.WIDTH(abm4_pkg::VAL_W), .DEPTH(ELEMENTS)) u_ram_now (
    .clk(clk), .we(wr_en && we_now), .waddr(wr_addr), .wdata(new_now),
    .re(in_fire), .raddr(rd_addr), .rdata(rd_now)
  );

  abm4_ram #(.WIDTH(abm4_pkg::VAL_W), .DEPTH(ELEMENTS)) u_ram_b1 (
    .clk(clk), .we(wr_en && we_b1), .waddr(wr_addr), .wdata(new_b1),
    .re(in_fire), .raddr(rd_addr), .rdata(rd_b1)
  );

  abm4_ram #(.WIDTH(abm4_pkg::VAL_W), .DEPTH(ELEMENTS)) u_ram_b2 (
    .clk(clk), .we(wr_en && we_b2), .waddr(wr_addr), .wdata(new_b2),
    .re(in_fire), .raddr(rd_addr), .rdata(rd_b2)
  );

  abm4_ram #(.WIDTH(abm4_pkg::VAL_W), .DEPTH(ELEMENTS)) u_ram_b3 (
    .clk(clk), .we(wr_en && we_b3), .waddr(wr_addr), .wdata(new_b3),
    .re(in_fire), .raddr(rd_addr), .rdata(rd_b3)
  );

  // Forward the last written row: the read at the same edge saw the old contents
  assign use_fwd = fwd_valid && (fwd_idx == st1_idx);
  assign cur_now = use_fwd ? fwd_now : rd_now;
  assign cur_b1  = use_fwd ? fwd_b1  : rd_b1;
  assign cur_b2  = use_fwd ? fwd_b2  : rd_b2;
  assign cur_b3  = use_fwd ? fwd_b3  : rd_b3;

  // Row update per kind
  always_comb begin
    new_now = cur_now;
    new_b1  = cur_b1;
    new_b2  = cur_b2;
    new_b3  = cur_b3;
    we_now  = 1'b0;
    we_b1   = 1'b0;
    we_b2   = 1'b0;
    we_b3   = 1'b0;
    case (st1_kind)
      abm4_pkg::KIND_SEED_B1: begin
        new_b1 = st1_d;
        we_b1  = 1'b1;
      end
      abm4_pkg::KIND_SEED_B2: begin
        new_b2 = st1_d;
        we_b2  = 1'b1;
      end
      abm4_pkg::KIND_SEED_B3: begin
        new_b3 = st1_d;
        we_b3  = 1'b1;
      end
      abm4_pkg::KIND_PREDICT: begin
        new_now = st1_d;
        we_now  = 1'b1;
      end
      abm4_pkg::KIND_CORRECT: begin
        new_b3 = cur_b2;
        new_b2 = cur_b1;
        new_b1 = cur_now;
        we_b1  = 1'b1;
        we_b2  = 1'b1;
        we_b3  = 1'b1;
      end
      default: ;
    endcase
  end

  assign wr_any = wr_en && (we_now || we_b1 || we_b2 || we_b3);

  // Forwarding register
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (wr_any) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_any) begin
      fwd_idx <= st1_idx;
      fwd_now <= new_now;
      fwd_b1  <= new_b1;
      fwd_b2  <= new_b2;
      fwd_b3  <= new_b3;
    end
  end

  // Weighted derivative sums, exact in Q16.16
  assign dx    = SW'(st1_d);
  assign x_now = SW'(cur_now);
  assign x_b1  = SW'(cur_b1);
  assign x_b2  = SW'(cur_b2);
  assign x_b3  = SW'(cur_b3);

  assign sum_pred = abm4_pkg::PC_F0 * dx - abm4_pkg::PC_F1 * x_b1
                  + abm4_pkg::PC_F2 * x_b2 - abm4_pkg::PC_F3 * x_b3;
  assign sum_corr = abm4_pkg::CC_FP * dx + abm4_pkg::CC_F0 * x_now
                  - abm4_pkg::CC_F1 * x_b1 + x_b2;

  assign sum.valid     = st1_valid && st1_result;
  assign sum.side.idx  = st1_idx;
  assign sum.side.corr = (st1_kind == abm4_pkg::KIND_CORRECT);
  assign sum.side.y    = st1_y;
  assign sum.s         = (st1_kind == abm4_pkg::KIND_CORRECT) ? sum_corr : sum_pred;

`ifndef SYNTHESIS
  // Back-to-back items on one element must take the forwarded row
  assert property (@(posedge clk) disable iff (rst)
    wr_any && in_fire && (element_index == st1_idx) |=> use_fwd)
    else $error("abm4_hist: missed forwarding on back-to-back element");

  // A held item keeps the history row it read
  assert property (@(posedge clk) disable iff (rst)
    st1_valid && !st1_go |=> $stable(rd_now) && $stable(rd_b1) &&
                              $stable(rd_b2) && $stable(rd_b3))
    else $error("abm4_hist: read data changed under a held item");

  // Input backpressure only comes from a blocked result-bearing item
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> st1_valid && st1_result && !adv)
    else $error("abm4_hist: input stalled without cause");
`endif

endmodule

// ===== rtl/core/abm4_step.sv =====
// Arithmetic pipe: h*S/24 scaling with rounding, divide by three, add and saturate.
module abm4_step (
  input  logic                              clk,
  input  logic                              rst,
  input  abm4_pkg::sum_t                    sum,
  input  logic signed [abm4_pkg::VAL_W-1:0] step_size,
  output logic                              adv,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [abm4_pkg::IDX_W-1:0]        out_index,
  output logic                              is_corrected,
  output logic signed [abm4_pkg::VAL_W-1:0] out_value,
  output logic                              saturated
);

  localparam int VW  = abm4_pkg::VAL_W;
  localparam int SW  = abm4_pkg::SUM_W;
  localparam int MW  = abm4_pkg::MS_W;
  localparam int SP  = abm4_pkg::SPLIT;
  localparam int PHW = abm4_pkg::PH_W;
  localparam int PLW = abm4_pkg::PL_W;
  localparam int QW  = abm4_pkg::Q_W;
  localparam int QLW = abm4_pkg::Q_LO_W;
  localparam int QHW = abm4_pkg::Q_HI_W;
  localparam int AWD = abm4_pkg::A_W;
  localparam int BW  = abm4_pkg::B_W;
  localparam int TW  = abm4_pkg::T_W;
  localparam int GW  = abm4_pkg::MAG_W;
  localparam int RW  = abm4_pkg::RES_W;
  localparam int PW  = abm4_pkg::PROD3_W;
  localparam int RS  = abm4_pkg::RECIP3_SHIFT;

  // Stage valids
  logic v2, v3, v4, v5, v6, v7;

  // Stage payloads
  abm4_pkg::side_t      side2, side3, side4, side5, side6, side7;
  logic signed [SW-1:0] s2;
  logic                 neg3, neg4, neg5, neg6, neg7;
  logic [VW-1:0]        mh3;
  logic [MW-1:0]        ms3;
  logic [PHW-1:0]       phi4;
  logic [PLW-1:0]       plo4;
  logic [QW-1:0]        q5;
  logic [AWD-1:0]       a6, a7;
  logic [QHW-1:0]       qh6;
  logic [QLW-1:0]       ql6;
  logic [BW-1:0]        b7;

  // Combinational per stage
  logic [SW-1:0]        s_abs;
  logic [VW-1:0]        mh_next;
  logic                 neg_next;
  logic [PHW-1:0]       phi_next;
  logic [PLW-1:0]       plo_next;
  logic [PLW:0]         plo_round;
  logic [QW-1:0]        q_next;
  logic [PW-1:0]        prod_a;
  logic [QHW-1:0]       three_a;
  logic [QHW-1:0]       rem_a;
  logic [TW-1:0]        t_div;
  logic [PW-1:0]        prod_b;
  logic [GW-1:0]        mag;
  logic signed [RW-1:0] delta;
  logic signed [RW-1:0] res;
  logic                 sat_hi, sat_lo;

  // Whole pipe moves while the result register can take a transaction
  assign adv = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      v7        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v2        <= sum.valid;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      v6        <= v5;
      v7        <= v6;
      out_valid <= v7;
    end
  end

  // Magnitudes and result sign
  assign s_abs    = s2[SW-1] ? SW'(-s2) : SW'(s2);
  assign mh_next  = step_size[VW-1] ? VW'(-step_size) : VW'(step_size);
  assign neg_next = s2[SW-1] ^ step_size[VW-1];

  // Split products |h| * |S|
  assign phi_next = PHW'(mh3) * PHW'(ms3[MW-1:SP]);
  assign plo_next = PLW'(mh3) * PLW'(ms3[SP-1:0]);

  // Rounded sum of the partial products
  assign plo_round = (PLW+1)'(plo4) + (PLW+1)'(abm4_pkg::ROUND_BIAS);
  assign q_next    = QW'(phi4) + QW'(plo_round >> SP);

  // Divide by three, upper half
  assign prod_a = PW'(q5[QW-1:QLW]) * PW'(abm4_pkg::RECIP3);

  // Divide by three, remainder carried into lower half
  assign three_a = QHW'(a6) + QHW'({a6, 1'b0});
  assign rem_a   = qh6 - three_a;
  assign t_div   = {rem_a[1:0], ql6};
  assign prod_b  = PW'(t_div) * PW'(abm4_pkg::RECIP3);

  // Signed add to y and saturation
  assign mag    = {a7, b7};
  assign delta  = neg7 ? -$signed(RW'(mag)) : $signed(RW'(mag));
  assign res    = RW'(side7.y) + delta;
  assign sat_hi = !res[RW-1] && (res[RW-2:VW-1] != '0);
  assign sat_lo = res[RW-1] && (res[RW-2:VW-1] != '1);

  // Stage registers
  always_ff @(posedge clk) begin
    if (adv) begin
      side2 <= sum.side;
      s2    <= sum.s;

      side3 <= side2;
      neg3  <= neg_next;
      mh3   <= mh_next;
      ms3   <= s_abs[MW-1:0];

      side4 <= side3;
      neg4  <= neg3;
      phi4  <= phi_next;
      plo4  <= plo_next;

      side5 <= side4;
      neg5  <= neg4;
      q5    <= q_next;

      side6 <= side5;
      neg6  <= neg5;
      a6    <= prod_a[RS +: AWD];
      qh6   <= q5[QW-1:QLW];
      ql6   <= q5[QLW-1:0];

      side7 <= side6;
      neg7  <= neg6;
      a7    <= a6;
      b7    <= prod_b[RS +: BW];

      out_index    <= side7.idx;
      is_corrected <= side7.corr;
      saturated    <= sat_hi || sat_lo;
      if (sat_hi) begin
        out_value <= abm4_pkg::VAL_MAX;
      end else if (sat_lo) begin
        out_value <= abm4_pkg::VAL_MIN;
      end else begin
        out_value <= res[VW-1:0];
      end
    end
  end

`ifndef SYNTHESIS
  // A clipped result sits at one of the range limits
  assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      (out_value == abm4_pkg::VAL_MAX) || (out_value == abm4_pkg::VAL_MIN))
    else $error("abm4_step: saturation flag without limit value");

  // A zero increment passes y through unclipped
  assert property (@(posedge clk) disable iff (rst)
    adv && v7 && (a7 == '0) && (b7 == '0) |=>
      out_valid && !saturated && (out_value == $past(side7.y)))
    else $error("abm4_step: zero increment altered the value");

  // The last stage lands in the result register with its own tag
  assert property (@(posedge clk) disable iff (rst)
    adv && v7 |=> out_valid && (out_index == $past(side7.idx)) &&
                  (is_corrected == $past(side7.corr)))
    else $error("abm4_step: result tag lost between stages");
`endif

endmodule

// ===== rtl/core/abm4_predictor_corrector_top.sv =====
// Top level of the ABM4 predictor-corrector step engine: register port and pipe.
//
//  Channel  | Signals                                              | Direction
//  ---------+------------------------------------------------------+----------
//  config   | psel penable pwrite paddr pwdata prdata pready       | APB slave
//  input    | in_valid in_ready kind element_index current_value   | sink
//           | derivative                                           |
//  result   | out_valid out_ready out_index is_corrected out_value | source
//           | saturated                                            |
//
// One transaction per cycle is accepted while in_ready is high; a predict or
// correct result is registered through the split multiplies, the rounding add
// and the two-step divide by three. Seed items and ignored items give no result.
// Reset sets the step size to 1.0 and empties the pipe; the history memories
// are not cleared and read as undefined until seeded.
// While a result is held with out_ready low the whole pipe holds; the input stalls only when the
// first stage holds a result-bearing item.
module abm4_predictor_corrector_top #(
  parameter int ELEMENTS = abm4_pkg::ELEMENTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [abm4_pkg::ADDR_W-1:0]       paddr,
  input  logic [abm4_pkg::VAL_W-1:0]        pwdata,
  output logic [abm4_pkg::VAL_W-1:0]        prdata,
  output logic                              pready,
  // Input items
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [abm4_pkg::KIND_W-1:0]       kind,
  input  logic [abm4_pkg::IDX_W-1:0]        element_index,
  input  logic signed [abm4_pkg::VAL_W-1:0] current_value,
  input  logic signed [abm4_pkg::VAL_W-1:0] derivative,
  // Result items
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [abm4_pkg::IDX_W-1:0]        out_index,
  output logic                              is_corrected,
  output logic signed [abm4_pkg::VAL_W-1:0] out_value,
  output logic                              saturated
);

  logic signed [abm4_pkg::VAL_W-1:0] step_size;
  logic                              reg_sel;
  logic                              reg_wr;
  logic                              adv;
  abm4_pkg::sum_t                    sum;

  // Register decode: register index is the word address bit
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == abm4_pkg::REG_STEP_SIZE);
  assign reg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? step_size : '0;

  // Step size register
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= abm4_pkg::STEP_RESET;
    end else if (reg_wr) begin
      step_size <= pwdata;
    end
  end

  // History memories and weighted sum
  abm4_hist #(.ELEMENTS(ELEMENTS)) u_hist (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .element_index (element_index),
    .current_value (current_value),
    .derivative    (derivative),
    .adv           (adv),
    .sum           (sum)
  );

  // Scaling, rounding and saturation
  abm4_step u_step (
    .clk          (clk),
    .rst          (rst),
    .sum          (sum),
    .step_size    (step_size),
    .adv          (adv),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_index    (out_index),
    .is_corrected (is_corrected),
    .out_value    (out_value),
    .saturated    (saturated)
  );

endmodule
